// ----- design/cag_pkg.sv -----
// Shared types, register codes and defaults for the camera activity gate.
package cag_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CAMERAS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_COUNTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEEK_MS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINGER_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SHOW_MS   = 3'd5;

  localparam logic [31:0] PEEK_MS_RST     = 32'd10000;
  localparam logic [31:0] LINGER_MS_RST   = 32'd30000;
  localparam logic [31:0] MIN_SHOW_MS_RST = 32'd10000;

  // Configuration register set
  typedef struct packed {
    logic        activity_mode;
    logic        motion_counts;
    logic [4:0]  camera_count;
    logic [31:0] peek_ms;
    logic [31:0] linger_ms;
    logic [31:0] min_show_ms;
  } cfg_t;

  // One input item (one camera)
  typedef struct packed {
    logic        feed_connected;
    logic        states_usable;
    logic [31:0] idle_ms;
    logic [31:0] now_ms;
    logic [7:0]  object_count;
    logic        motion;
    logic [31:0] last_object_ms;
    logic [31:0] last_motion_ms;
  } item_t;

  // One result item
  typedef struct packed {
    logic [3:0] camera_index;
    logic       visible;
    logic       filtered;
    logic       wake_edge;
    logic       quiet;
    logic       pass_end;
  } result_t;

  // Pass decisions handed to the per-camera store
  typedef struct packed {
    logic show_all;
    logic trusted;
  } pass_ctl_t;

  // Per-camera outcome handed back to pass control
  typedef struct packed {
    logic wake_hit;
    logic shown;
  } cam_stat_t;

  // Pass-level result flags
  typedef struct packed {
    logic filtered;
    logic wake_edge;
    logic quiet;
    logic pass_end;
  } pass_flags_t;

endpackage

// ----- design/camera_activity_gate_core.sv -----
// Top level of the camera activity gate: config registers and datapath wiring.
//
//  channel  | signals                           | direction
//  ---------+-----------------------------------+----------
//  item     | item_valid, item_ready, item      | in
//  result   | result_valid, result_ready, result| out
//  config   | cfg_we, cfg_index, cfg_data       | in
//
// One item per cycle while results are taken: the camera's stored entry is read,
// the filter decided and the entry written in the cycle the item is accepted;
// the result lands in the output register on that edge.
// item_ready is low only while a held result is not taken.
// Reset clears config to defaults and all per-camera and pass state.
// With camera_count zero items are taken and dropped.
module camera_activity_gate_core #(
  parameter int MAX_CAMERAS = cag_pkg::MAX_CAMERAS_DEF,
  parameter int TIME_BITS   = cag_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  cag_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output cag_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [cag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cag_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cag_pkg::*;

  localparam int IDX_W = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;

  cfg_t        cfg;
  logic        clear;
  logic        accept;
  logic        count_zero;
  logic [IDX_W-1:0] idx;
  pass_ctl_t   ctl;
  pass_flags_t flags;
  cam_stat_t   stat;
  logic        visible;
  logic        can_load;
  result_t     result_next;

  assign clear      = cfg_we && (cfg_index == CFG_CAMERA_COUNT);
  assign item_ready = can_load;
  assign accept     = item_valid && item_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.activity_mode <= 1'b0;
      cfg.motion_counts <= 1'b0;
      cfg.camera_count  <= '0;
      cfg.peek_ms       <= PEEK_MS_RST;
      cfg.linger_ms     <= LINGER_MS_RST;
      cfg.min_show_ms   <= MIN_SHOW_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVITY_MODE: cfg.activity_mode <= cfg_data[0];
        CFG_MOTION_COUNTS: cfg.motion_counts <= cfg_data[0];
        CFG_CAMERA_COUNT:  cfg.camera_count  <= cfg_data[4:0];
        CFG_PEEK_MS:       cfg.peek_ms       <= cfg_data;
        CFG_LINGER_MS:     cfg.linger_ms     <= cfg_data;
        CFG_MIN_SHOW_MS:   cfg.min_show_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  cag_pass_ctrl #(
    .MAX_CAMERAS (MAX_CAMERAS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_pass (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clear      (clear),
    .accept     (accept),
    .item       (item),
    .stat       (stat),
    .idx        (idx),
    .count_zero (count_zero),
    .ctl        (ctl),
    .flags      (flags)
  );

  cag_camera_store #(
    .MAX_CAMERAS (MAX_CAMERAS),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .clear   (clear),
    .accept  (accept && !count_zero),
    .item    (item),
    .idx     (idx),
    .ctl     (ctl),
    .visible (visible),
    .stat    (stat)
  );

  // Result assembly
  always_comb begin
    result_next.camera_index = 4'(idx);
    result_next.visible      = visible;
    result_next.filtered     = flags.filtered;
    result_next.wake_edge    = flags.wake_edge;
    result_next.quiet        = flags.quiet;
    result_next.pass_end     = flags.pass_end;
  end

  cag_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && !count_zero),
    .data_in      (result_next),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- design/cag_pass_ctrl.sv -----
// Pass sequencing: camera index, connect edge, show-all decision, pass summary.
module cag_pass_ctrl #(
  parameter int MAX_CAMERAS = 16,
  parameter int TIME_BITS   = 32,
  parameter int IDX_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cag_pkg::cfg_t         cfg,
  input  logic                  clear,
  input  logic                  accept,
  input  cag_pkg::item_t        item,
  input  cag_pkg::cam_stat_t    stat,
  output logic [IDX_W-1:0]      idx,
  output logic                  count_zero,
  output cag_pkg::pass_ctl_t    ctl,
  output cag_pkg::pass_flags_t  flags
);
  import cag_pkg::*;

  localparam int CNT_W = $clog2(MAX_CAMERAS + 1);
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [IDX_W-1:0]     item_index;
  logic                 prev_connected;
  logic [TIME_BITS-1:0] connect_stamp;
  logic                 pass_show_all;
  logic                 pass_trusted;
  logic                 wake_seen;
  logic                 any_shown;

  logic [CNT_W-1:0]     count;
  logic                 first;
  logic                 last;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] stamp_eff;
  logic [TIME_BITS-1:0] since_connect;
  logic                 settling;
  logic                 peeking;
  logic                 want_filter;
  logic                 show_all_new;
  logic                 wake_next;
  logic                 any_next;

  // Effective camera count, clamped to the store depth
  always_comb begin
    if (32'(cfg.camera_count) > 32'(MAX_CAMERAS)) begin
      count = CNT_W'(MAX_CAMERAS);
    end else begin
      count = CNT_W'(cfg.camera_count);
    end
  end

  assign count_zero = (count == '0);

  // Current camera; a stale index past the count restarts the pass
  always_comb begin
    if (CNT_W'(item_index) >= count) begin
      idx = '0;
    end else begin
      idx = item_index;
    end
  end

  assign first = (idx == '0);
  assign last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign now_t = TIME_BITS'(item.now_ms);

  // Show-all decision for the first item of a pass
  always_comb begin
    if (item.feed_connected && !prev_connected) begin
      stamp_eff = now_t;
    end else begin
      stamp_eff = connect_stamp;
    end
    since_connect = now_t - stamp_eff;
    settling      = item.feed_connected &&
                    (CMP_W'(since_connect) < CMP_W'(cfg.peek_ms));
    want_filter   = cfg.activity_mode && item.feed_connected && item.states_usable;
    peeking       = item.idle_ms < cfg.peek_ms;
    show_all_new  = !want_filter || peeking || settling;
  end

  // Pass decisions seen by this item
  always_comb begin
    if (first) begin
      ctl.show_all = show_all_new;
      ctl.trusted  = item.feed_connected && item.states_usable;
    end else begin
      ctl.show_all = pass_show_all;
      ctl.trusted  = pass_trusted;
    end
  end

  // Running pass summary including this item
  assign wake_next = (!first && wake_seen) || stat.wake_hit;
  assign any_next  = (!first && any_shown) || stat.shown;

  assign flags.filtered  = !ctl.show_all;
  assign flags.wake_edge = last && wake_next;
  assign flags.quiet     = last && !ctl.show_all && !any_next;
  assign flags.pass_end  = last;

  // Connect edge tracking survives a count write
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_connected <= 1'b0;
      connect_stamp  <= '0;
    end else if (accept && !count_zero && first && !clear) begin
      prev_connected <= item.feed_connected;
      connect_stamp  <= stamp_eff;
    end
  end

  // Pass state
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      item_index    <= '0;
      pass_show_all <= 1'b0;
      pass_trusted  <= 1'b0;
      wake_seen     <= 1'b0;
      any_shown     <= 1'b0;
    end else if (accept && !count_zero) begin
      item_index    <= last ? '0 : idx + IDX_W'(1);
      pass_show_all <= ctl.show_all;
      pass_trusted  <= ctl.trusted;
      wake_seen     <= wake_next;
      any_shown     <= any_next;
    end
  end

endmodule

// ----- design/cag_camera_store.sv -----
// Per-camera state (activity bit, shown-since stamp) and visibility logic.
module cag_camera_store #(
  parameter int MAX_CAMERAS = 16,
  parameter int TIME_BITS   = 32,
  parameter int IDX_W       = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  cag_pkg::cfg_t       cfg,
  input  logic                clear,
  input  logic                accept,
  input  cag_pkg::item_t      item,
  input  logic [IDX_W-1:0]    idx,
  input  cag_pkg::pass_ctl_t  ctl,
  output logic                visible,
  output cag_pkg::cam_stat_t  stat
);
  import cag_pkg::*;

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [MAX_CAMERAS-1:0] prev_active;
  logic [TIME_BITS-1:0]   shown_stamp [MAX_CAMERAS];

  logic                 active;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] last_obj;
  logic [TIME_BITS-1:0] last_mot;
  logic [TIME_BITS-1:0] last_act;
  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] since_act;
  logic [TIME_BITS-1:0] since_shown;
  logic                 lingering;
  logic                 holding;
  logic [TIME_BITS-1:0] stamp_next;

  assign now_t    = TIME_BITS'(item.now_ms);
  assign last_obj = TIME_BITS'(item.last_object_ms);
  assign last_mot = TIME_BITS'(item.last_motion_ms);
  assign stamp    = shown_stamp[idx];
  assign active   = (item.object_count != '0) || (cfg.motion_counts && item.motion);

  // Filter decision: show-all, active, lingering after activity, or min-show hold
  always_comb begin
    if (cfg.motion_counts && (last_mot > last_obj)) begin
      last_act = last_mot;
    end else begin
      last_act = last_obj;
    end
    since_act   = now_t - last_act;
    since_shown = now_t - stamp;
    lingering   = (last_act != '0) && (CMP_W'(since_act) < CMP_W'(cfg.linger_ms));
    holding     = (stamp != '0) && (CMP_W'(since_shown) < CMP_W'(cfg.min_show_ms));
    visible     = ctl.show_all || active || lingering || holding;
    if (ctl.show_all || !visible) begin
      stamp_next = '0;
    end else if (stamp == '0) begin
      stamp_next = now_t;
    end else begin
      stamp_next = stamp;
    end
  end

  assign stat.wake_hit = ctl.trusted && active && !prev_active[idx];
  assign stat.shown    = !ctl.show_all && visible;

  // Store update for the current camera
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev_active <= '0;
      for (int k = 0; k < MAX_CAMERAS; k++) begin
        shown_stamp[k] <= '0;
      end
    end else if (accept) begin
      prev_active[idx] <= ctl.trusted && active;
      shown_stamp[idx] <= stamp_next;
    end
  end

endmodule

// ----- design/cag_out_reg.sv -----
// Result register with valid/ready handshake.
module cag_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cag_pkg::result_t data_in,
  output logic             can_load,
  output logic             result_valid,
  input  logic             result_ready,
  output cag_pkg::result_t result
);
  import cag_pkg::*;

  // Free when empty or when the held item leaves this cycle
  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= data_in;
    end
  end

endmodule
